[hdl/ttb_pkg.sv]
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared codes and helpers of the Trickle timer bank.
// ----------------------------------------------------------------------------
package ttb_pkg;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_START      = 2'd1,
    CMD_CONSISTENT = 2'd2,
    CMD_RESET      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_REFUSED = 2'd1,
    KIND_XMIT    = 2'd2
  } kind_t;

  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned HEARD_BITS = 8;

  // One step of the right-shift Galois LFSR; a zero state is stepped as if it were one.
  function automatic logic [31:0] lfsr_step(input logic [31:0] cur);
    logic [31:0] v;
    v = (cur == 32'd0) ? 32'd1 : cur;
    lfsr_step = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
  endfunction

endpackage

[hdl/trickle_timer_bank.sv]
// ----------------------------------------------------------------------------
// trickle_timer_bank
// Bank of Trickle timers with a shared serial remainder unit.
// ----------------------------------------------------------------------------
// Usage: each in_ item carries a command. Tick counts every used timer down
// and may emit transmit items, start claims the lowest free slot and answers
// with one item (slot allocated or refused), consistent and reset give no
// item. out_last marks the final item caused by an input item.
// Slots are served one after another by a sequencer. Every draw of a random
// value goes through one shared restoring remainder unit that handles one
// quotient bit per cycle. in_ready is low while an item is in work.
// A transmit is held until the scan shows whether another follows, so the
// last one can carry out_last. Results pass through a single output
// register; the sequencer waits while it is full and the receiver stalls,
// so nothing is lost.
// cfg_ writes load the seed into the LFSR at once; they are taken only while
// the sequencer is idle. Reset frees all slots and loads the LFSR with one.
// ----------------------------------------------------------------------------
module trickle_timer_bank #(
  parameter int TIMERS = 4,
  parameter int INTERVAL_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_command,
  input  logic [1:0]               in_timer_index,
  input  logic [INTERVAL_BITS-1:0] in_min_interval_in,
  input  logic [INTERVAL_BITS-1:0] in_max_interval_in,
  input  logic [7:0]               in_redundancy_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_kind,
  output logic [1:0]               out_slot,
  output logic                     out_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [31:0]              cfg_random_seed
);
  import ttb_pkg::*;

  localparam int IB = INTERVAL_BITS;
  localparam int SW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CW = $clog2(33) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DIV, S_SLOT, S_XMIT, S_DONE, S_OUT
  } state_t;

  // What the remainder result is used for.
  typedef enum logic [1:0] {
    D_FIRST, D_SPLIT
  } dgoal_t;

  state_t      state_r;
  dgoal_t      goal_r;
  logic [31:0] lfsr_r;
  logic [TIMERS-1:0] used_r, second_r;
  logic [IB-1:0] ivl_r [TIMERS];
  logic [IB-1:0] split_r [TIMERS];
  logic [IB-1:0] left_r [TIMERS];
  logic [IB-1:0] mn_r [TIMERS];
  logic [IB-1:0] mx_r [TIMERS];
  logic [HEARD_BITS-1:0] heard_r [TIMERS];
  logic [HEARD_BITS-1:0] thr_r [TIMERS];

  logic [1:0]  cmd_r;
  logic [IB-1:0] mnin_r, mxin_r;
  logic [7:0]  kin_r;
  logic [SW-1:0] cur_r;
  logic [2:0]  nres_r;
  logic        pend_r;
  logic        hit_r;
  logic [SW-1:0] pslot_r;
  // remainder unit: rem = num mod den, one bit per cycle
  logic [31:0] num_r;
  logic [IB:0] rem_r;
  logic [IB-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic        ov_r;
  logic [1:0]  okind_r;
  logic [1:0]  oslot_r;
  logic        olast_r;

  logic [IB:0] shl;
  logic [IB:0] sub;
  logic [IB-1:0] half;
  logic [IB:0] dbl;
  logic [SW-1:0] free_idx;
  logic        free_ok;
  logic [SW-1:0] idx;
  logic        idx_ok;
  logic [31:0] next_draw;
  logic        out_free;
  logic        refuse;
  logic        last_slot;
  logic        emit;

  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_kind  = okind_r;
  assign out_slot  = oslot_r;
  assign out_last  = olast_r;

  assign shl = {rem_r[IB-1:0], num_r[31]};
  assign sub = shl - {1'b0, den_r};
  assign half = (ivl_r[cur_r] >> 1) == '0 ? IB'(1) : (ivl_r[cur_r] >> 1);
  assign dbl = {ivl_r[cur_r], 1'b0};
  assign next_draw = lfsr_step(lfsr_r);
  assign idx = SW'(in_timer_index);
  assign idx_ok = (32'(in_timer_index) < TIMERS) && used_r[idx];

  assign out_free  = !ov_r || out_ready;
  assign refuse    = mnin_r < IB'(2) || mxin_r <= mnin_r || !free_ok;
  assign last_slot = (32'(cur_r) == TIMERS - 1);
  assign emit = out_free && ((state_r == S_START && refuse) ||
                             (state_r == S_DONE && cmd_r == CMD_START) ||
                             (state_r == S_OUT && (hit_r || (last_slot && pend_r))));

  always_comb begin
    free_idx = '0;
    free_ok = 1'b0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_idx = SW'(i);
        free_ok = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      lfsr_r   <= 32'd1;
      used_r   <= '0;
      second_r <= '0;
      ov_r     <= 1'b0;
      pend_r   <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      if (emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (cfg_valid && cfg_ready) lfsr_r <= cfg_random_seed;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r  <= in_command;
            mnin_r <= IB'(in_min_interval_in);
            mxin_r <= IB'(in_max_interval_in);
            kin_r  <= in_redundancy_in;
            cur_r  <= (cmd_t'(in_command) == CMD_RESET) ? idx : '0;
            nres_r <= '0;
            unique case (cmd_t'(in_command))
              CMD_TICK:  state_r <= S_SLOT;
              CMD_START: state_r <= S_START;
              CMD_CONSISTENT: begin
                if (idx_ok && heard_r[idx] != '1) heard_r[idx] <= heard_r[idx] + 1'b1;
              end
              CMD_RESET: begin
                if (idx_ok) begin
                  ivl_r[idx] <= mn_r[idx];
                  state_r <= S_XMIT;
                end
              end
              default: ;
            endcase
          end
        end
        S_START: begin
          if (out_free) begin
            if (refuse) begin
              okind_r <= KIND_REFUSED; oslot_r <= '0;
              olast_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              cur_r <= free_idx;
              used_r[free_idx] <= 1'b1;
              mn_r[free_idx] <= mnin_r;
              mx_r[free_idx] <= mxin_r;
              thr_r[free_idx] <= kin_r;
              lfsr_r <= next_draw;
              num_r <= next_draw;
              den_r <= mxin_r - mnin_r;
              rem_r <= '0;
              cnt_r <= '0;
              goal_r <= D_FIRST;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          num_r <= {num_r[30:0], 1'b0};
          rem_r <= sub[IB] ? shl : sub;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(31)) begin
            if (goal_r == D_FIRST) begin
              ivl_r[cur_r] <= mnin_r + (sub[IB] ? shl[IB-1:0] : sub[IB-1:0]);
              goal_r <= D_SPLIT;
              state_r <= S_XMIT;
            end else begin
              split_r[cur_r] <= den_r + (sub[IB] ? shl[IB-1:0] : sub[IB-1:0]);
              left_r[cur_r]  <= den_r + (sub[IB] ? shl[IB-1:0] : sub[IB-1:0]);
              state_r <= S_DONE;
            end
          end
        end
        // begin an interval: draw the transmit point
        S_XMIT: begin
          heard_r[cur_r] <= '0;
          second_r[cur_r] <= 1'b0;
          lfsr_r <= next_draw;
          num_r <= next_draw;
          den_r <= half;
          rem_r <= '0;
          cnt_r <= '0;
          goal_r <= D_SPLIT;
          state_r <= S_DIV;
        end
        S_DONE: begin
          if (cmd_r == CMD_START) begin
            if (out_free) begin
              okind_r <= KIND_ALLOC; oslot_r <= 2'(cur_r);
              olast_r <= 1'b1;
              state_r <= S_IDLE;
            end
          end else if (cmd_r == CMD_TICK) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SLOT: begin
          if (used_r[cur_r]) begin
            if (left_r[cur_r] > IB'(1)) begin
              left_r[cur_r] <= left_r[cur_r] - 1'b1;
              state_r <= S_OUT;
            end else if (!second_r[cur_r]) begin
              if (heard_r[cur_r] < thr_r[cur_r] && nres_r < 3'(MAX_RESULTS)) begin
                nres_r <= nres_r + 1'b1;
                // a held transmit is flushed first when another one comes
                if (pend_r) hit_r <= 1'b1;
                else begin
                  pend_r <= 1'b1;
                  pslot_r <= cur_r;
                end
              end
              second_r[cur_r] <= 1'b1;
              left_r[cur_r] <= (ivl_r[cur_r] > split_r[cur_r]) ?
                               ivl_r[cur_r] - split_r[cur_r] : IB'(1);
              state_r <= S_OUT;
            end else begin
              ivl_r[cur_r] <= (dbl > {1'b0, mx_r[cur_r]}) ? mx_r[cur_r] : dbl[IB-1:0];
              state_r <= S_XMIT;
            end
          end else begin
            state_r <= S_OUT;
          end
        end
        // emit a held transmit once it is known whether another follows, then advance
        S_OUT: begin
          if (hit_r) begin
            if (out_free) begin
              okind_r <= KIND_XMIT; oslot_r <= 2'(pslot_r);
              olast_r <= 1'b0;
              pslot_r <= cur_r;
              hit_r <= 1'b0;
            end
          end else if (last_slot) begin
            if (pend_r) begin
              if (out_free) begin
                okind_r <= KIND_XMIT; oslot_r <= 2'(pslot_r);
                olast_r <= 1'b1;
                pend_r <= 1'b0;
                state_r <= S_IDLE;
              end
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            cur_r <= cur_r + 1'b1;
            state_r <= S_SLOT;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/trickle_timer_bank_checks.sv]
// ----------------------------------------------------------------------------
// trickle_timer_bank_checks
// Port-level checks of the Trickle timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module trickle_timer_bank_checks (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [1:0] out_slot
);
  import ttb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_slot))
    else $error("result item changed while stalled");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_ALLOC || out_kind == KIND_REFUSED ||
                   out_kind == KIND_XMIT))
    else $error("illegal result kind");
  a_refused_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_REFUSED |-> out_slot == 2'd0)
    else $error("refused start names a slot");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_TICK || in_command == CMD_START)
    |=> !in_ready)
    else $error("item taken while busy");
endmodule

bind trickle_timer_bank trickle_timer_bank_checks u_checks (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .in_command(in_command),
  .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
  .out_slot(out_slot)
);
